/* rtl/sdi_pkg.sv */
// shared types, codes and command frame table for the sd card spi start-up sequencer
// no dependencies; imported by every module under rtl
package sdi_pkg;

  // phase codes, also reported on the step field
  typedef enum logic [3:0] {
    PH_IDLE        = 4'd0,
    PH_DUMMY       = 4'd1,
    PH_BUSY        = 4'd2,
    PH_CMD0_SEND   = 4'd3,
    PH_CMD0_POLL   = 4'd4,
    PH_CMD8_SEND   = 4'd5,
    PH_CMD8_R1     = 4'd6,
    PH_CMD8_TAIL   = 4'd7,
    PH_CMD58_SEND  = 4'd8,
    PH_CMD58_R1    = 4'd9,
    PH_CMD58_OCR   = 4'd10,
    PH_CMD55_SEND  = 4'd11,
    PH_CMD55_R1    = 4'd12,
    PH_ACMD41_SEND = 4'd13,
    PH_ACMD41_R1   = 4'd14,
    PH_DONE        = 4'd15
  } phase_t;

  // input command codes
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_XFER  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // configuration register indexes
  localparam logic CFG_BUSY_TIMEOUT = 1'b0;
  localparam logic CFG_DUMMY_BYTES  = 1'b1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [15:0] BUSY_TIMEOUT_RST = 16'd300;
  localparam logic [7:0]  DUMMY_BYTES_RST  = 8'd10;

  localparam logic [7:0]  IDLE_BYTE = 8'hFF;
  localparam logic [7:0]  R1_IDLE   = 8'h01;
  localparam logic [7:0]  FRAME_LEN = 8'd6;
  localparam logic [7:0]  TAIL_LEN  = 8'd4;
  localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

  // six-byte command frames: cmd0, cmd8, cmd58, cmd55, acmd41
  localparam logic [7:0] FRAMES [5][6] = '{
    '{8'h40, 8'h00, 8'h00, 8'h00, 8'h00, 8'h95},
    '{8'h48, 8'h00, 8'h00, 8'h01, 8'hAA, 8'h87},
    '{8'h7A, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF},
    '{8'h77, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF},
    '{8'h69, 8'h40, 8'h00, 8'h00, 8'h00, 8'hFF}
  };

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] rx_byte;
  } sdi_in_t;

  typedef struct packed {
    logic [7:0]  tx_byte;
    logic        tx_valid;
    logic        chip_select;
    logic [3:0]  step;
    logic [7:0]  idle_response;
    logic [7:0]  cmd8_response;
    logic [31:0] ocr_value;
    logic [7:0]  ready_response;
    logic        done_res;
    logic        busy_timed_out;
  } sdi_out_t;

  typedef struct packed {
    logic [15:0] busy_timeout_ms;
    logic [7:0]  dummy_clock_bytes;
  } sdi_cfg_t;

  // byte of the frame sent in a given send phase
  function automatic logic [7:0] frame_byte(phase_t ph, logic [7:0] idx);
    logic [2:0] f;
    logic [2:0] i;
    unique case (ph)
      PH_CMD8_SEND:   f = 3'd1;
      PH_CMD58_SEND:  f = 3'd2;
      PH_CMD55_SEND:  f = 3'd3;
      PH_ACMD41_SEND: f = 3'd4;
      default:        f = 3'd0;
    endcase
    i = (idx < FRAME_LEN) ? idx[2:0] : 3'd0;
    return FRAMES[f][i];
  endfunction

endpackage

/* rtl/sdi_cfg_regs.sv */
// configuration registers of the sd card spi start-up sequencer
// depends on sdi_pkg
module sdi_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [sdi_pkg::CFG_DATA_W-1:0]      cfg_data,
  output sdi_pkg::sdi_cfg_t                   cfg
);
  import sdi_pkg::*;

  logic [15:0] busy_timeout_r;
  logic [7:0]  dummy_bytes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_timeout_r <= BUSY_TIMEOUT_RST;
      dummy_bytes_r  <= DUMMY_BYTES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BUSY_TIMEOUT: busy_timeout_r <= cfg_data;
        CFG_DUMMY_BYTES:  dummy_bytes_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign cfg.busy_timeout_ms   = busy_timeout_r;
  assign cfg.dummy_clock_bytes = dummy_bytes_r;

endmodule

/* rtl/sdi_seq_core.sv */
// sequencer state and next-state logic, one item per cycle while fire is high
// depends on sdi_pkg
module sdi_seq_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  sdi_pkg::sdi_in_t  item,
  input  sdi_pkg::sdi_cfg_t cfg,
  output sdi_pkg::sdi_out_t result
);
  import sdi_pkg::*;

  phase_t      phase_r, phase_nxt;
  phase_t      after_r, after_nxt;
  logic [7:0]  idx_r, idx_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic        cs_r, cs_nxt;
  logic [7:0]  cmd0_r, cmd0_nxt;
  logic [7:0]  cmd8_r, cmd8_nxt;
  logic [31:0] ocr_r, ocr_nxt;
  logic [7:0]  acmd_r, acmd_nxt;
  logic        fin_r, fin_nxt;
  logic        tmo_r, tmo_nxt;

  logic [7:0]  tx;
  logic        vld;
  logic [7:0]  idx_inc;
  logic [7:0]  limit;
  logic [7:0]  rx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      after_r   <= PH_IDLE;
      idx_r     <= '0;
      elapsed_r <= '0;
      cs_r      <= 1'b1;
      cmd0_r    <= '0;
      cmd8_r    <= '0;
      ocr_r     <= '0;
      acmd_r    <= IDLE_BYTE;
      fin_r     <= 1'b0;
      tmo_r     <= 1'b0;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      after_r   <= after_nxt;
      idx_r     <= idx_nxt;
      elapsed_r <= elapsed_nxt;
      cs_r      <= cs_nxt;
      cmd0_r    <= cmd0_nxt;
      cmd8_r    <= cmd8_nxt;
      ocr_r     <= ocr_nxt;
      acmd_r    <= acmd_nxt;
      fin_r     <= fin_nxt;
      tmo_r     <= tmo_nxt;
    end
  end

  assign idx_inc = idx_r + 8'd1;
  assign limit   = (cfg.dummy_clock_bytes == 8'd0) ? 8'd1 : cfg.dummy_clock_bytes;
  assign rx      = item.rx_byte;

  always_comb begin
    phase_nxt   = phase_r;
    after_nxt   = after_r;
    idx_nxt     = idx_r;
    elapsed_nxt = elapsed_r;
    cs_nxt      = cs_r;
    cmd0_nxt    = cmd0_r;
    cmd8_nxt    = cmd8_r;
    ocr_nxt     = ocr_r;
    acmd_nxt    = acmd_r;
    fin_nxt     = fin_r;
    tmo_nxt     = tmo_r;
    tx          = IDLE_BYTE;
    vld         = 1'b0;

    case (item.command)
      CMD_START: begin
        phase_nxt   = PH_DUMMY;
        after_nxt   = PH_IDLE;
        idx_nxt     = '0;
        elapsed_nxt = '0;
        cs_nxt      = 1'b1;
        cmd0_nxt    = '0;
        cmd8_nxt    = '0;
        ocr_nxt     = '0;
        acmd_nxt    = IDLE_BYTE;
        fin_nxt     = 1'b0;
        tmo_nxt     = 1'b0;
        vld         = 1'b1;
      end
      CMD_XFER: begin
        vld = 1'b1;
        unique case (phase_r)
          PH_DUMMY: begin
            idx_nxt = idx_inc;
            if (idx_inc >= limit) begin
              phase_nxt = PH_BUSY; after_nxt = PH_CMD0_SEND;
              elapsed_nxt = '0; tmo_nxt = 1'b0; cs_nxt = 1'b0;
            end
          end
          PH_BUSY: begin
            if (rx == IDLE_BYTE || elapsed_r >= cfg.busy_timeout_ms) begin
              if (rx != IDLE_BYTE) tmo_nxt = 1'b1;
              phase_nxt = after_r;
              idx_nxt   = '0;
              tx        = frame_byte(after_r, 8'd0);
            end
          end
          PH_CMD0_SEND, PH_CMD8_SEND, PH_CMD58_SEND, PH_CMD55_SEND,
          PH_ACMD41_SEND: begin
            if (idx_inc < FRAME_LEN) begin
              idx_nxt = idx_inc;
              tx      = frame_byte(phase_r, idx_inc);
            end else begin
              // frame sent, move to its reply phase
              phase_nxt = phase_t'(phase_r + 4'd1);
              idx_nxt   = '0;
            end
          end
          PH_CMD0_POLL: begin
            cmd0_nxt = rx;
            if (rx == R1_IDLE) begin
              phase_nxt = PH_BUSY; after_nxt = PH_CMD8_SEND;
              elapsed_nxt = '0; tmo_nxt = 1'b0; cs_nxt = 1'b0;
            end
          end
          PH_CMD8_R1: begin
            cmd8_nxt = rx;
            if (!rx[7]) begin
              phase_nxt = PH_CMD8_TAIL;
              idx_nxt   = '0;
            end
          end
          PH_CMD8_TAIL: begin
            idx_nxt = idx_inc;
            if (idx_inc >= TAIL_LEN) begin
              phase_nxt = PH_BUSY; after_nxt = PH_CMD58_SEND;
              elapsed_nxt = '0; tmo_nxt = 1'b0; cs_nxt = 1'b0;
            end
          end
          PH_CMD58_R1: begin
            if (!rx[7]) begin
              ocr_nxt   = '0;
              phase_nxt = PH_CMD58_OCR;
              idx_nxt   = '0;
            end
          end
          PH_CMD58_OCR: begin
            ocr_nxt = {ocr_r[23:0], rx};
            idx_nxt = idx_inc;
            if (idx_inc >= TAIL_LEN) begin
              phase_nxt = PH_BUSY; after_nxt = PH_CMD55_SEND;
              elapsed_nxt = '0; tmo_nxt = 1'b0; cs_nxt = 1'b0;
            end
          end
          PH_CMD55_R1: begin
            if (!rx[7]) begin
              phase_nxt = PH_BUSY; after_nxt = PH_ACMD41_SEND;
              elapsed_nxt = '0; tmo_nxt = 1'b0; cs_nxt = 1'b0;
            end
          end
          PH_ACMD41_R1: begin
            acmd_nxt = rx;
            if (!rx[7]) begin
              if (rx == 8'h00) begin
                phase_nxt = PH_DONE;
                fin_nxt   = 1'b1;
                vld       = 1'b0;
              end else begin
                phase_nxt = PH_BUSY; after_nxt = PH_CMD55_SEND;
                elapsed_nxt = '0; tmo_nxt = 1'b0; cs_nxt = 1'b0;
              end
            end
          end
          default: vld = 1'b0;
        endcase
      end
      CMD_TICK: begin
        if (phase_r == PH_BUSY && elapsed_r != ELAPSED_MAX)
          elapsed_nxt = elapsed_r + 16'd1;
      end
      default: ;
    endcase

    if (!vld) tx = IDLE_BYTE;
  end

  assign result.tx_byte        = tx;
  assign result.tx_valid       = vld;
  assign result.chip_select    = cs_nxt;
  assign result.step           = phase_nxt;
  assign result.idle_response  = cmd0_nxt;
  assign result.cmd8_response  = cmd8_nxt;
  assign result.ocr_value      = ocr_nxt;
  assign result.ready_response = acmd_nxt;
  assign result.done_res       = fin_nxt;
  assign result.busy_timed_out = tmo_nxt;

endmodule

/* rtl/sd_spi_init_sequencer_top.sv */
// top level of the sd card spi start-up sequencer: input register, sequencer, result register
// depends on sdi_pkg, sdi_cfg_regs, sdi_seq_core
//
//   channel   direction  handshake            payload
//   in_       in         in_valid/in_ready    sdi_in_t  (command, rx_byte)
//   out_      out        out_valid/out_ready  sdi_out_t (tx_byte ... busy_timed_out)
//   cfg_      in         cfg_we               cfg_index, cfg_data (write only)
//
// every item gives exactly one result item, via the input and result registers
// sustained rate is one item per cycle while out_ready holds, set by the state
// update in the sequencer core; input and result registers each hold one item
// a stalled result register stops the core and then the input register;
// the input side keeps taking items while either register has room
// reset is synchronous, active low; no clearing pass is needed
module sd_spi_init_sequencer_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  sdi_pkg::sdi_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output sdi_pkg::sdi_out_t              out_data,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [sdi_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sdi_pkg::*;

  logic      s1_valid_r;
  sdi_in_t   s1_data_r;
  logic      out_valid_r;
  sdi_out_t  out_data_r;
  logic      advance;
  logic      core_fire;
  sdi_cfg_t  cfg;
  sdi_out_t  result;

  // the result register can take a new item when empty or being drained
  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || advance;
  assign core_fire = s1_valid_r && advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  sdi_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencer state moves only when its result is taken into the result register
  sdi_seq_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (core_fire),
    .item   (s1_data_r),
    .cfg    (cfg),
    .result (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (core_fire) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // an item leaving the input register always lands in the result register
  a_fire_lands : assert property (@(posedge clk) disable iff (!rst_n)
    core_fire |=> out_valid_r)
    else $error("item lost between input and result register");

  // chip select is only high before the first busy wait
  a_cs_high : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.chip_select) |->
      (out_data_r.step == PH_IDLE || out_data_r.step == PH_DUMMY))
    else $error("chip select high outside start-up clocks");

  // completion is only reported in the done phase
  a_done_phase : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.done_res) |-> (out_data_r.step == PH_DONE))
    else $error("done flag outside done phase");

  // no exchange requested means the idle byte is shown
  a_idle_byte : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.tx_valid) |-> (out_data_r.tx_byte == IDLE_BYTE))
    else $error("tx byte not idle while no exchange requested");

endmodule
